// ----- rtl/format_string_expander_assert.svh -----
// Assertion macros for the format string expander.
// Used by the top level; no other dependencies.
`ifndef FORMAT_STRING_EXPANDER_ASSERT_SVH
`define FORMAT_STRING_EXPANDER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define FSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// An antecedent that forces a consequent in the next cycle.
`define FSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fse_pkg.sv -----
// Shared types and constants for the format string expander.
// No dependencies; imported by the controller, datapath and top level.
package fse_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 32;

    localparam logic [BYTE_W-1:0]  CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0]  CH_D       = 8'h64;
    localparam logic [BYTE_W-1:0]  CH_S       = 8'h73;
    localparam logic [BYTE_W-1:0]  CH_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0]  CH_ZERO    = 8'h30;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push_byte;   // send the input byte as the final character
        logic push_minus;  // send a minus sign
        logic push_digit;  // send the leading BCD digit
        logic load_arg;    // load the argument magnitude and clear the BCD word
        logic conv_step;   // one shift-and-add-3 step
        logic digit_step;  // drop the leading BCD digit
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;    // the output register can take a character this cycle
        logic arg_neg;     // the input argument is negative
        logic conv_done;   // this conversion step is the final one
        logic top_zero;    // the leading BCD digit is zero
        logic digit_last;  // the leading BCD digit is the last one
        logic overflow;    // the magnitude had more digits than the BCD word holds
    } sts_t;

endpackage

// ----- rtl/format_string_expander.sv -----
// Top level of the format string expander: controller, datapath and checks.
// Depends on fse_pkg, fse_ctrl, fse_dp and format_string_expander_assert.svh.
//
// Usage: the slave channel takes one format or string byte per request, with
// the integer argument alongside it; tuser = 1 marks a string argument byte.
// The master channel returns one character per request together with the
// running character count, which saturates at its maximum; tlast marks the
// final character caused by one input request.
// A plain, echoed or string byte appears on the master side in the cycle after
// it is taken, and the next request is taken in that same cycle if the output
// register drains. A '%' followed by 's' or a '%' alone yields nothing.
// A %d conversion loads the magnitude when the request is accepted; the
// bit-serial shift-and-add-3 converter then takes one bit per cycle, and the
// scan skips leading zeros and emits the digits, one per cycle while the
// receiver takes them. No new request is taken until the last digit is in the
// output register.
// Reset clears the pending '%', the character count and the output valid flag.
// When the receiver stalls, the current character holds in the output
// register and no new request is taken until it can drain.
module format_string_expander #(
    parameter int ARG_BITS   = 32,
    parameter int MAX_DIGITS = 10,
    localparam int S_DATA_W  = ((fse_pkg::BYTE_W + ARG_BITS + 7) / 8) * 8,
    localparam int M_DATA_W  = fse_pkg::BYTE_W + fse_pkg::COUNT_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Input requests.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // in_byte[7:0], int_arg, zero padding
    input  logic                s_tuser,   // mode
    // Result requests.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_byte[7:0], char_count[39:8]
    output logic                m_tlast
);
    import fse_pkg::*;

    cmd_t               cmd;
    sts_t               sts;
    logic [BYTE_W-1:0]  out_byte;
    logic [COUNT_W-1:0] char_count;

    fse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .mode     (s_tuser),
        .in_byte  (s_tdata[BYTE_W-1:0]),
        .sts      (sts),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    fse_dp #(
        .ARG_BITS   (ARG_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_byte    (s_tdata[BYTE_W-1:0]),
        .int_arg    (s_tdata[BYTE_W +: ARG_BITS]),
        .cmd        (cmd),
        .sts        (sts),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tlast    (m_tlast),
        .out_byte   (out_byte),
        .char_count (char_count)
    );

    assign m_tdata = {char_count, out_byte};

`include "format_string_expander_assert.svh"

    // A character is only loaded when the output register can take it.
    `FSE_ASSERT(a_push_free, !(cmd.push_byte || cmd.push_minus || cmd.push_digit) || sts.out_free, "character pushed into a full output register")
    // A string byte comes straight back as a final character.
    `FSE_ASSERT_NEXT(a_string_echo, s_tvalid && s_tready && s_tuser, m_tvalid && m_tlast && (m_tdata[7:0] == $past(s_tdata[7:0])), "string byte not echoed")
    // Only one kind of character is chosen in a cycle.
    `FSE_ASSERT(a_one_push, $onehot0({cmd.push_byte, cmd.push_minus, cmd.push_digit}), "more than one character source selected")

endmodule

// ----- rtl/fse_ctrl.sv -----
// Controller state machine of the format string expander.
// Depends on fse_pkg; drives the datapath through cmd_t and reads sts_t.
module fse_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        mode,
    input  logic [fse_pkg::BYTE_W-1:0]  in_byte,
    input  fse_pkg::sts_t               sts,
    output fse_pkg::cmd_t               cmd,
    output logic                        s_tready
);
    import fse_pkg::*;

    state_t state_reg, state_next;
    logic   pending_reg, pending_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) && sts.out_free;
    assign accept   = s_tvalid && s_tready;

    // Next state, pending percent flag and datapath commands.
    always_comb begin
        state_next   = state_reg;
        pending_next = pending_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (mode) begin
                        cmd.push_byte = 1'b1;
                    end else if (pending_reg) begin
                        pending_next = 1'b0;
                        if (in_byte == CH_D) begin
                            cmd.load_arg   = 1'b1;
                            cmd.push_minus = sts.arg_neg;
                            state_next     = ST_CONV;
                        end else if (in_byte != CH_S) begin
                            cmd.push_byte = 1'b1;
                        end
                    end else if (in_byte == CH_PERCENT) begin
                        pending_next = 1'b1;
                    end else begin
                        cmd.push_byte = 1'b1;
                    end
                end
            end
            ST_CONV: begin
                cmd.conv_step = 1'b1;
                if (sts.conv_done) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Skip leading zeros; a lone zero or an overflowed word is printed whole.
                if (sts.overflow || !sts.top_zero || sts.digit_last) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.digit_step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.push_digit = 1'b1;
                    cmd.digit_step = 1'b1;
                    if (sts.digit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// ----- rtl/fse_dp.sv -----
// Datapath of the format string expander: bit-serial binary to BCD converter,
// digit shifter, character counter and output register. Depends on fse_pkg.
module fse_dp #(
    parameter int ARG_BITS   = 32,
    parameter int MAX_DIGITS = 10
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [fse_pkg::BYTE_W-1:0]   in_byte,
    input  logic [ARG_BITS-1:0]          int_arg,
    input  fse_pkg::cmd_t                cmd,
    output fse_pkg::sts_t                sts,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic                         m_tlast,
    output logic [fse_pkg::BYTE_W-1:0]   out_byte,
    output logic [fse_pkg::COUNT_W-1:0]  char_count
);
    import fse_pkg::*;

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int BIT_W = $clog2(ARG_BITS);
    localparam int DIG_W = $clog2(MAX_DIGITS + 1);

    logic [ARG_BITS-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next, bcd_adj;
    logic                ovf_reg, ovf_next;
    logic [BIT_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [DIG_W-1:0]    dig_cnt_reg, dig_cnt_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_last_reg, out_last_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic [COUNT_W-1:0]  total_reg, total_next;

    logic                push;
    logic [3:0]          top_digit;

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign push      = cmd.push_byte || cmd.push_minus || cmd.push_digit;

    // Status toward the controller.
    always_comb begin
        sts.out_free   = !out_valid_reg || m_tready;
        sts.arg_neg    = int_arg[ARG_BITS-1];
        sts.conv_done  = (bit_cnt_reg == '0);
        sts.top_zero   = (top_digit == 4'd0);
        sts.digit_last = (dig_cnt_reg == DIG_W'(1));
        sts.overflow   = ovf_reg;
    end

    // Add 3 to every BCD digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                (bcd_reg[4*i +: 4] + 4'd3) : bcd_reg[4*i +: 4];
        end
    end

    // Converter and digit shifter.
    always_comb begin
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        ovf_next     = ovf_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        if (cmd.load_arg) begin
            mag_next     = int_arg[ARG_BITS-1] ? (~int_arg + 1'b1) : int_arg;
            bcd_next     = '0;
            ovf_next     = 1'b0;
            bit_cnt_next = BIT_W'(ARG_BITS - 1);
            dig_cnt_next = DIG_W'(MAX_DIGITS);
        end else if (cmd.conv_step) begin
            bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[ARG_BITS-1]};
            ovf_next     = ovf_reg | bcd_adj[BCD_W-1];
            mag_next     = {mag_reg[ARG_BITS-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - 1'b1;
        end else if (cmd.digit_step) begin
            bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
            dig_cnt_next = dig_cnt_reg - 1'b1;
        end
    end

    // Output register and saturating character count.
    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_last_next  = out_last_reg;
        out_byte_next  = out_byte_reg;
        out_count_next = out_count_reg;
        total_next     = total_reg;
        if (push) begin
            out_valid_next = 1'b1;
            total_next     = (total_reg == COUNT_MAX) ? total_reg : (total_reg + 1'b1);
            out_count_next = total_next;
            if (cmd.push_byte) begin
                out_byte_next = in_byte;
                out_last_next = 1'b1;
            end else if (cmd.push_minus) begin
                out_byte_next = CH_MINUS;
                out_last_next = 1'b0;
            end else begin
                out_byte_next = CH_ZERO + {4'd0, top_digit};
                out_last_next = sts.digit_last;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        mag_reg       <= mag_next;
        bcd_reg       <= bcd_next;
        ovf_reg       <= ovf_next;
        bit_cnt_reg   <= bit_cnt_next;
        dig_cnt_reg   <= dig_cnt_next;
        out_last_reg  <= out_last_next;
        out_byte_reg  <= out_byte_next;
        out_count_reg <= out_count_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tlast    = out_last_reg;
    assign out_byte   = out_byte_reg;
    assign char_count = out_count_reg;

endmodule

// ----- dv/tb_format_string_expander.sv -----
// Self-checking testbench for format_string_expander: drives format and string bytes,
// predicts every emitted character with its count and tlast, and compares the stream.
// Depends on fse_pkg and the format_string_expander RTL.
module tb_format_string_expander;
    timeunit 1ns;
    timeprecision 1ps;

    import fse_pkg::*;

    localparam int  ARG_W            = 32;
    localparam int  DIGITS_MAX       = 10;
    localparam int  S_W              = ((BYTE_W + ARG_W + 7) / 8) * 8;
    localparam int  M_W              = BYTE_W + COUNT_W;
    localparam bit  MODE_FORMAT      = 1'b0;
    localparam bit  MODE_STRING      = 1'b1;
    localparam int  LONG_HOLD_CYCLES = 300;
    localparam int  SETTLE_CYCLES    = 80;

    // One emitted character as the block should report it.
    typedef struct packed {
        logic [BYTE_W-1:0]  ch;
        logic               last;
        logic [COUNT_W-1:0] count;
    } char_result_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [S_W-1:0]    s_tdata  = '0;   // in_byte[7:0], int_arg[39:8]
    logic              s_tuser  = 1'b0; // mode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [M_W-1:0]    m_tdata;         // out_byte[7:0], char_count[39:8]
    logic              m_tlast;

    // Predicted state of the interpreter.
    bit                 fmt_percent_pending;
    logic [COUNT_W-1:0] chars_emitted;
    char_result_t       expected_chars[$];

    int  error_count;
    int  requests_sent;
    bit  hold_output;
    bit  quiet;

    format_string_expander dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("MISMATCH: %s", msg);
        end
    endfunction

    // Append one character to the expected stream, advancing the saturating count.
    function automatic void push_char(logic [BYTE_W-1:0] ch);
        char_result_t r;
        if (chars_emitted != COUNT_MAX) begin
            chars_emitted++;
        end
        r.ch    = ch;
        r.last  = 1'b0;
        r.count = chars_emitted;
        expected_chars.push_back(r);
    endfunction

    // Sign and decimal digits of the argument, most significant digit first.
    function automatic void push_decimal(logic [ARG_W-1:0] arg);
        logic [3:0]      digits [DIGITS_MAX];
        longint unsigned mag;
        int              n;
        mag = {32'd0, arg};
        n   = 0;
        if (arg[ARG_W-1]) begin
            push_char(CH_MINUS);
            mag = 64'h1_0000_0000 - mag;
        end
        do begin
            digits[n] = 4'(mag % 10);
            mag       = mag / 10;
            n++;
        end while (mag != 0 && n < DIGITS_MAX);
        for (int i = n - 1; i >= 0; i--) begin
            push_char(CH_ZERO + BYTE_W'(digits[i]));
        end
    endfunction

    // Expected characters caused by one accepted request.
    function automatic void predict_expansion(bit mode, logic [BYTE_W-1:0] ch,
                                              logic [ARG_W-1:0] arg);
        int           size_prior;
        char_result_t r;
        size_prior = expected_chars.size();
        if (mode == MODE_STRING) begin
            push_char(ch);
        end else if (fmt_percent_pending) begin
            fmt_percent_pending = 1'b0;
            if (ch == CH_D) begin
                push_decimal(arg);
            end else if (ch != CH_S) begin
                push_char(ch);
            end
        end else if (ch == CH_PERCENT) begin
            fmt_percent_pending = 1'b1;
        end else begin
            push_char(ch);
        end
        if (expected_chars.size() > size_prior) begin
            r      = expected_chars.pop_back();
            r.last = 1'b1;
            expected_chars.push_back(r);
        end
    endfunction

    // Offer one request and hold it until taken; sometimes idle afterwards.
    task automatic send_request(bit mode, logic [BYTE_W-1:0] ch, logic [ARG_W-1:0] arg);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= S_W'({arg, ch});
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predict_expansion(mode, ch, arg);
        requests_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every predicted character has arrived.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_chars.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [ARG_W-1:0] pick_arg();
        logic [ARG_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 999);
            1: v = -ARG_W'($urandom_range(1, 99999));
            2: begin
                case ($urandom_range(0, 7))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'd0;
                    4: v = 32'd1_000_000_000;
                    5: v = 32'd999_999_999;
                    6: v = 32'd10;
                    default: v = -32'sd10;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // One well-formed piece of a format string, or noise.
    task automatic send_random_piece();
        logic [BYTE_W-1:0] ch;
        int                k;
        k  = $urandom_range(0, 9);
        ch = 8'($urandom_range(0, 255));
        case (k)
            0, 1, 2: begin
                if (ch == CH_PERCENT) begin
                    ch = ch ^ 8'h80;
                end
                send_request(MODE_FORMAT, ch, $urandom);
            end
            3, 4: begin
                send_request(MODE_FORMAT, CH_PERCENT, $urandom);
                send_request(MODE_FORMAT, CH_D, pick_arg());
            end
            5: begin
                send_request(MODE_FORMAT, CH_PERCENT, $urandom);
                send_request(MODE_FORMAT, CH_S, $urandom);
                repeat ($urandom_range(0, 4)) begin
                    send_request(MODE_STRING, 8'($urandom_range(0, 255)), $urandom);
                end
            end
            6: begin
                send_request(MODE_FORMAT, CH_PERCENT, $urandom);
                send_request(MODE_FORMAT, CH_PERCENT, $urandom);
            end
            7: begin
                send_request(MODE_FORMAT, CH_PERCENT, $urandom);
                send_request(MODE_FORMAT, ch, pick_arg());
            end
            8: begin
                send_request(1'($urandom_range(0, 1)), ch, pick_arg());
            end
            default: begin
                send_request(MODE_FORMAT, CH_PERCENT, $urandom);
                send_request(MODE_STRING, ch, $urandom);
                send_request(MODE_FORMAT, ($urandom_range(0, 1) != 0) ? CH_D : ch,
                             pick_arg());
            end
        endcase
    endtask

    // Field extremes, every conversion and the named corner cases.
    task automatic test_directed();
        send_request(MODE_FORMAT, 8'h00, 32'd0);          // zero format byte is echoed
        send_request(MODE_FORMAT, 8'hFF, 32'hFFFF_FFFF);
        send_request(MODE_FORMAT, "A", 32'h5555_5555);
        send_request(MODE_FORMAT, CH_PERCENT, 32'd0);
        send_request(MODE_FORMAT, CH_PERCENT, 32'd0);     // %% gives one percent
        send_request(MODE_FORMAT, CH_PERCENT, 32'd0);
        send_request(MODE_FORMAT, CH_D, 32'd0);           // zero prints a single digit
        send_request(MODE_FORMAT, CH_PERCENT, 32'd0);
        send_request(MODE_FORMAT, CH_D, 32'h8000_0000);   // most negative argument
        send_request(MODE_FORMAT, CH_PERCENT, 32'd0);
        send_request(MODE_FORMAT, CH_D, 32'h7FFF_FFFF);
        send_request(MODE_FORMAT, CH_PERCENT, 32'd0);
        send_request(MODE_FORMAT, CH_D, 32'hFFFF_FFFF);
        send_request(MODE_FORMAT, CH_PERCENT, 32'd0);
        send_request(MODE_FORMAT, CH_S, 32'd0);           // %s itself emits nothing
        send_request(MODE_STRING, 8'h00, 32'hAAAA_AAAA);
        send_request(MODE_STRING, 8'hFF, 32'd0);
        send_request(MODE_FORMAT, CH_PERCENT, 32'd0);
        send_request(MODE_FORMAT, "x", 32'd0);            // unknown conversion is echoed
        // A trailing percent stays pending across string bytes.
        send_request(MODE_FORMAT, CH_PERCENT, 32'd0);
        send_request(MODE_STRING, CH_PERCENT, 32'd0);
        send_request(MODE_STRING, "Z", 32'd0);
        send_request(MODE_FORMAT, CH_D, -32'sd45);
        send_request(MODE_STRING, CH_D, 32'd7);           // string byte never converts
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_long_stall();
        hold_output = 1'b1;
        for (int i = 0; i < 6; i++) begin
            send_request(MODE_FORMAT, "a" + 8'(i), $urandom);
            send_request(MODE_FORMAT, CH_PERCENT, $urandom);
            send_request(MODE_FORMAT, CH_D, pick_arg());
        end
        wait_for_drain();
    endtask

    task automatic test_random(int target);
        int stop_at;
        stop_at = requests_sent + target;
        while (requests_sent < stop_at) begin
            send_random_piece();
            // Now and then the sender waits for the output side to empty.
            if (!quiet && $urandom_range(0, 19) == 0) begin
                wait_for_drain();
            end
        end
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_quiet_tail();
        quiet = 1'b1;
        test_random(20);
    endtask

    // Receiver: random stall bursts, a long hold on request, none when quiet.
    initial begin
        @(posedge aclk);
        while (!aresetn) begin
            @(posedge aclk);
        end
        forever begin
            if (hold_output) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                hold_output = 1'b0;
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    // Compare each accepted character with the oldest prediction.
    always @(posedge aclk) begin
        char_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                note_error($sformatf("unexpected char %h count %0d last %b",
                                     m_tdata[7:0], m_tdata[39:8], m_tlast));
            end else begin
                want = expected_chars.pop_front();
                if (m_tdata[7:0] !== want.ch || m_tlast !== want.last ||
                    m_tdata[39:8] !== want.count) begin
                    note_error($sformatf(
                        "char exp %h got %h, last exp %b got %b, count exp %0d got %0d",
                        want.ch, m_tdata[7:0], want.last, m_tlast,
                        want.count, m_tdata[39:8]));
                end
            end
        end
    end

    // Overall time limit.
    initial begin
        #6_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        fmt_percent_pending = 1'b0;
        chars_emitted       = '0;
        error_count         = 0;
        requests_sent       = 0;
        hold_output         = 1'b0;
        quiet               = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_long_stall();
        test_random(110);
        test_quiet_tail();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_chars.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/fse_pkg.sv
rtl/fse_ctrl.sv
rtl/fse_dp.sv
rtl/format_string_expander.sv
dv/tb_format_string_expander.sv
